// ===== design/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared constants and types for the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int unsigned CLASS_DEPTH  = 16;
  localparam int unsigned NUMBER_WIDTH = 16;

  localparam int unsigned IDX_W = $clog2(CLASS_DEPTH);
  localparam int unsigned CNT_W = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned LEN_W = $clog2(2 * CLASS_DEPTH + 1);

  localparam logic CMD_ENQ   = 1'b0;
  localparam logic CMD_DEQ   = 1'b1;
  localparam logic CLASS_VIP = 1'b1;
  localparam logic CLASS_REG = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // per-FIFO control from the queue logic
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

// ===== design/tcpq_fifo.sv =====
// ----------------------------------------------------------------------------
// tcpq_fifo
// Circular FIFO for one service class, with count and registered read word.
// ----------------------------------------------------------------------------
module tcpq_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tcpq_pkg::fifo_ctl_t                ctl_i,
  input  logic [tcpq_pkg::NUMBER_WIDTH-1:0]  data_i,
  output logic [tcpq_pkg::CNT_W-1:0]         count_o,
  output logic [tcpq_pkg::NUMBER_WIDTH-1:0]  data_o
);
  import tcpq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLASS_DEPTH - 1);

  logic [NUMBER_WIDTH-1:0] mem_q [CLASS_DEPTH];
  logic [NUMBER_WIDTH-1:0] data_q;
  logic [IDX_W-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]        count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.push) begin
      tail_d  = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
      count_d = count_q + CNT_W'(1);
    end
    if (ctl_i.pop) begin
      head_d  = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // storage, read word held until the next pop
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= data_i;
    end
    if (ctl_i.pop) begin
      data_q <= mem_q[head_q];
    end
  end

  assign count_o = count_q;
  assign data_o  = data_q;

endmodule

// ===== design/two_class_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_queue_top
// Two-class queue: VIP entries leave before regular ones, FIFO within class.
// ----------------------------------------------------------------------------
//  channel | handshake              | word
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o  | command, priority_class, item_number
//  out     | out_valid_o / out_ready_i| item_valid, out_class, out_number,
//          |                          | status, total_length, is_empty
//
// One word in and one word out per cycle while out_ready_i is high; a result
// is registered: a taken input word passes from the input register to the
// result register.
// Queue state updates at the edge that loads the result register.
// Reset clears pointers and counts; the entry stores are not cleared.
// A stall on the out side holds the result and fills the input register,
// then drops in_ready_o.
module two_class_priority_queue_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               command_i,
  input  logic                               priority_class_i,
  input  logic [tcpq_pkg::NUMBER_WIDTH-1:0]  item_number_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               item_valid_o,
  output logic                               out_class_o,
  output logic [tcpq_pkg::NUMBER_WIDTH-1:0]  out_number_o,
  output tcpq_pkg::status_e                  status_o,
  output logic [tcpq_pkg::LEN_W-1:0]         total_length_o,
  output logic                               is_empty_o
);
  import tcpq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CLASS_DEPTH);

  // input register
  logic                    in_vld_q;
  logic                    cmd_q, cls_q;
  logic [NUMBER_WIDTH-1:0] num_q;

  // result register
  logic                    out_vld_q;
  logic                    item_vld_q, item_vld_d;
  logic                    ocls_q, ocls_d;
  status_e                 status_q, status_d;
  logic [LEN_W-1:0]        total_q, total_d;
  logic                    empty_q, empty_d;

  logic                    out_free, fire;
  fifo_ctl_t               vip_ctl, reg_ctl;
  logic [CNT_W-1:0]        vip_cnt, reg_cnt, vip_cnt_nxt, reg_cnt_nxt;
  logic [NUMBER_WIDTH-1:0] vip_data, reg_data;

  assign out_free   = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= command_i;
      cls_q <= priority_class_i;
      num_q <= item_number_i;
    end
  end

  always_comb begin
    vip_ctl    = '0;
    reg_ctl    = '0;
    item_vld_d = 1'b0;
    ocls_d     = CLASS_REG;
    status_d   = STATUS_OK;
    if (cmd_q == CMD_ENQ) begin
      if (cls_q == CLASS_VIP) begin
        if (vip_cnt == FULL_CNT) status_d = STATUS_FULL;
        else vip_ctl.push = fire;
      end else begin
        if (reg_cnt == FULL_CNT) status_d = STATUS_FULL;
        else reg_ctl.push = fire;
      end
    end else begin
      if (vip_cnt != '0) begin
        vip_ctl.pop = fire;
        item_vld_d  = 1'b1;
        ocls_d      = CLASS_VIP;
      end else if (reg_cnt != '0) begin
        reg_ctl.pop = fire;
        item_vld_d  = 1'b1;
      end else begin
        status_d = STATUS_EMPTY;
      end
    end
    vip_cnt_nxt = vip_cnt + CNT_W'(vip_ctl.push) - CNT_W'(vip_ctl.pop);
    reg_cnt_nxt = reg_cnt + CNT_W'(reg_ctl.push) - CNT_W'(reg_ctl.pop);
    total_d     = LEN_W'(vip_cnt_nxt) + LEN_W'(reg_cnt_nxt);
    empty_d     = (total_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_vld_q <= item_vld_d;
      ocls_q     <= ocls_d;
      status_q   <= status_d;
      total_q    <= total_d;
      empty_q    <= empty_d;
    end
  end

  tcpq_fifo u_vip_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (vip_ctl),
    .data_i  (num_q),
    .count_o (vip_cnt),
    .data_o  (vip_data)
  );

  tcpq_fifo u_reg_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (reg_ctl),
    .data_i  (num_q),
    .count_o (reg_cnt),
    .data_o  (reg_data)
  );

  // FIFO read words only change on a pop, which happens only when the result register loads
  assign out_valid_o    = out_vld_q;
  assign item_valid_o   = item_vld_q;
  assign out_class_o    = ocls_q;
  assign out_number_o   = !item_vld_q ? '0 : ((ocls_q == CLASS_VIP) ? vip_data : reg_data);
  assign status_o       = status_q;
  assign total_length_o = total_q;
  assign is_empty_o     = empty_q;

  a_no_push_pop_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vip_ctl.push && vip_ctl.pop) && !(reg_ctl.push && reg_ctl.pop))
    else $error("push and pop on one class fifo");

  a_reg_pop_vip_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reg_ctl.pop |-> (vip_cnt == '0))
    else $error("regular pop while VIP entries held");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vip_cnt <= FULL_CNT) && (reg_cnt <= FULL_CNT))
    else $error("class count beyond depth");

  a_result_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (total_q == LEN_W'($past(vip_cnt_nxt)) + LEN_W'($past(reg_cnt_nxt))))
    else $error("total length mismatch");

  a_item_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && item_vld_q) |-> (status_q == STATUS_OK && !empty_q == (total_q != '0)))
    else $error("returned word with bad status");

endmodule
